/* rtl/i2cee_pkg.sv */
`timescale 1ns / 1ps
package i2cee_pkg;

  localparam int MEM_DEPTH     = 65536;
  localparam int ADDR_WIDTH    = 16;
  localparam int MEM_AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int CHIP_LOG2_MAX = (ADDR_WIDTH < 16) ? ADDR_WIDTH : 16;
  localparam int PAGE_LOG2_MAX = 8;

  typedef enum logic [1:0] {
    OP_WR_BYTE = 2'd0,
    OP_END     = 2'd1,
    OP_READ    = 2'd2,
    OP_PRELOAD = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_ADDR_COUNT = 2'd0,
    CFG_CHIP_LOG2  = 2'd1,
    CFG_PAGE_LOG2  = 2'd2,
    CFG_UNUSED     = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DELIVER
  } state_t;

  typedef struct packed {
    op_t         operation;
    logic [7:0]  data_byte;
    logic [15:0] preload_address;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [15:0] pointer_after;
    logic        address_complete;
  } out_item_t;

  typedef struct packed {
    logic load_item;
    logic mem_access;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

/* rtl/i2c_eeprom_byte_engine.sv */
`timescale 1ns / 1ps
// Byte engine of an I2C serial EEPROM. Each accepted word is one bus event (write byte,
// end of write, read byte, preload byte) and yields exactly one result word. An item
// passes through capture at acceptance, one access of the single-port 64 KiB byte
// memory, then update of the pointer state and the output register. The result reaches
// the output register after the memory access, and the next word can be accepted in the
// cycle in which it appears; a stalled output adds its
// stall. The output register lets the next word be accepted while a result still waits.
// Memory contents are undefined after reset; read only locations that were written or
// preloaded. Configuration may be written only while the engine is idle.
module i2c_eeprom_byte_engine (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  i2cee_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output i2cee_pkg::out_item_t out_data,
  input  logic                 cfg_write_en,
  input  logic [1:0]           cfg_index,
  input  logic [4:0]           cfg_wdata
);
  import i2cee_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  i2cee_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  i2cee_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .cmd          (cmd),
    .status       (status)
  );

endmodule

/* rtl/i2cee_ram.sv */
`timescale 1ns / 1ps
module i2cee_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                     clk,
  input  logic                                     en,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                         wdata,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/i2cee_ctrl.sv */
`timescale 1ns / 1ps
module i2cee_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  i2cee_pkg::dp_status_t  status,
  output i2cee_pkg::ctrl_cmd_t   cmd
);
  import i2cee_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    in_ready       = 1'b0;
    cmd.load_item  = 1'b0;
    cmd.mem_access = 1'b0;
    cmd.commit     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        cmd.mem_access = 1'b1;
        state_nxt      = ST_DELIVER;
      end
      ST_DELIVER: begin
        // hold until the output register can take the word
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/i2cee_dp.sv */
`timescale 1ns / 1ps
module i2cee_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  i2cee_pkg::in_item_t   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output i2cee_pkg::out_item_t  out_data,
  input  logic                  cfg_write_en,
  input  logic [1:0]            cfg_index,
  input  logic [4:0]            cfg_wdata,
  input  i2cee_pkg::ctrl_cmd_t  cmd,
  output i2cee_pkg::dp_status_t status
);
  import i2cee_pkg::*;

  logic [1:0]  addr_count_r;
  logic [4:0]  chip_log2_r;
  logic [3:0]  page_log2_r;
  logic [15:0] ptr_r, ptr_nxt;
  logic [7:0]  hi_r, hi_nxt;
  logic [1:0]  seen_r, seen_nxt;
  logic        out_valid_r;
  out_item_t   out_data_r;
  in_item_t    item_r;

  logic [1:0]  need;
  logic [4:0]  chip_l2;
  logic [3:0]  page_cl;
  logic [4:0]  page_l2;
  logic [16:0] chip_m17;
  logic [16:0] page_m17;
  logic [15:0] chip_mask;
  logic [15:0] page_mask;
  logic [15:0] rd_ptr;
  logic        complete_now;
  logic [1:0]  seen_inc;
  logic [7:0]  hi_new;
  logic [15:0] addr_word;
  logic [15:0] mem_addr16;
  logic        mem_we;
  logic [7:0]  mem_rdata;

  // effective configuration
  assign need = {addr_count_r[1], ~addr_count_r[1]};

  always_comb begin
    if (chip_log2_r == 5'd0) begin
      chip_l2 = 5'd1;
    end else if (chip_log2_r > 5'(CHIP_LOG2_MAX)) begin
      chip_l2 = 5'(CHIP_LOG2_MAX);
    end else begin
      chip_l2 = chip_log2_r;
    end
    page_cl = (page_log2_r > 4'(PAGE_LOG2_MAX)) ? 4'(PAGE_LOG2_MAX) : page_log2_r;
    page_l2 = ({1'b0, page_cl} > chip_l2) ? chip_l2 : {1'b0, page_cl};
  end

  assign chip_m17  = (17'd1 << chip_l2) - 17'd1;
  assign page_m17  = (17'd1 << page_l2) - 17'd1;
  assign chip_mask = chip_m17[15:0];
  assign page_mask = page_m17[15:0];

  assign rd_ptr       = ptr_r & chip_mask;
  assign complete_now = (seen_r >= need);
  assign seen_inc     = seen_r + 2'd1;
  assign hi_new       = (seen_r == 2'd0) ? item_r.data_byte : hi_r;
  assign addr_word    = (need == 2'd2) ? {hi_new, item_r.data_byte} : {8'd0, hi_new};

  // memory port
  always_comb begin
    mem_we     = 1'b0;
    mem_addr16 = ptr_r;
    unique case (item_r.operation)
      OP_WR_BYTE: begin
        mem_we     = complete_now;
        mem_addr16 = ptr_r;
      end
      OP_READ: begin
        mem_addr16 = rd_ptr;
      end
      OP_PRELOAD: begin
        mem_we     = 1'b1;
        mem_addr16 = item_r.preload_address;
      end
      OP_END: begin
        mem_addr16 = ptr_r;
      end
      default: begin
        mem_addr16 = ptr_r;
      end
    endcase
  end

  i2cee_ram #(
    .WIDTH (8),
    .DEPTH (MEM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .en    (cmd.mem_access && (mem_we || (item_r.operation == OP_READ))),
    .we    (mem_we),
    .addr  (mem_addr16[MEM_AW-1:0]),
    .wdata (item_r.data_byte),
    .rdata (mem_rdata)
  );

  // pointer and address state
  always_comb begin
    ptr_nxt  = ptr_r;
    hi_nxt   = hi_r;
    seen_nxt = seen_r;
    if (cmd.commit) begin
      unique case (item_r.operation)
        OP_WR_BYTE: begin
          if (!complete_now) begin
            hi_nxt   = hi_new;
            seen_nxt = seen_inc;
            if (seen_inc >= need) begin
              ptr_nxt = addr_word & chip_mask;
            end
          end else begin
            ptr_nxt = (ptr_r & ~page_mask) | ((ptr_r + 16'd1) & page_mask);
          end
        end
        OP_END: begin
          seen_nxt = 2'd0;
        end
        OP_READ: begin
          ptr_nxt = (rd_ptr + 16'd1) & chip_mask;
        end
        OP_PRELOAD: begin
          ptr_nxt = ptr_r;
        end
        default: begin
          ptr_nxt = ptr_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_count_r <= 2'd2;
      chip_log2_r  <= 5'd15;
      page_log2_r  <= 4'd6;
      ptr_r        <= '0;
      hi_r         <= '0;
      seen_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_ADDR_COUNT: addr_count_r <= cfg_wdata[1:0];
          CFG_CHIP_LOG2:  chip_log2_r  <= cfg_wdata;
          CFG_PAGE_LOG2:  page_log2_r  <= cfg_wdata[3:0];
          CFG_UNUSED:     addr_count_r <= addr_count_r;
          default:        addr_count_r <= addr_count_r;
        endcase
      end
      ptr_r  <= ptr_nxt;
      hi_r   <= hi_nxt;
      seen_r <= seen_nxt;
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r <= in_data;
    end
    if (cmd.commit) begin
      out_data_r.read_data        <= (item_r.operation == OP_READ) ? mem_rdata : 8'd0;
      out_data_r.pointer_after    <= ptr_nxt;
      out_data_r.address_complete <= (seen_nxt >= need);
    end
  end

  assign status.out_free = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;
  assign out_data        = out_data_r;

endmodule

/* dv/tb_i2c_eeprom_byte_engine.sv */
`timescale 1ns / 1ps
module tb_i2c_eeprom_byte_engine;
  import i2cee_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASES      = 11;

  class eeprom_image;
    logic [7:0]  mem [MEM_DEPTH];
    bit          known [MEM_DEPTH];
    logic [15:0] pointer;
    logic [7:0]  high_byte;
    int          bytes_seen;
    int          addr_count;
    int          chip_log2;
    int          page_log2;
    int          failures;
    out_item_t   awaited_results [$];

    function new();
      pointer    = '0;
      high_byte  = '0;
      bytes_seen = 0;
      addr_count = 2;
      chip_log2  = 15;
      page_log2  = 6;
      failures   = 0;
    endfunction

    function int need_bytes();
      if (addr_count == 0) return 1;
      if (addr_count > 2) return 2;
      return addr_count;
    endfunction

    function int chip_bits();
      int v;
      v = chip_log2;
      if (v == 0) v = 1;
      if (v > CHIP_LOG2_MAX) v = CHIP_LOG2_MAX;
      return v;
    endfunction

    function int page_bits();
      int v;
      v = page_log2;
      if (v > PAGE_LOG2_MAX) v = PAGE_LOG2_MAX;
      if (v > chip_bits()) v = chip_bits();
      return v;
    endfunction

    function int read_addr();
      return pointer & ((1 << chip_bits()) - 1);
    endfunction

    function void note_word(in_item_t w);
      out_item_t res;
      int cmask;
      int pmask;
      int p;
      int addr;
      cmask = (1 << chip_bits()) - 1;
      pmask = (1 << page_bits()) - 1;
      res = '0;
      case (w.operation)
        OP_WR_BYTE: begin
          if (bytes_seen < need_bytes()) begin
            if (bytes_seen == 0) high_byte = w.data_byte;
            bytes_seen++;
            if (bytes_seen >= need_bytes()) begin
              if (need_bytes() == 2) addr = {high_byte, w.data_byte};
              else addr = high_byte;
              pointer = 16'(addr & cmask);
            end
          end else begin
            mem[pointer]   = w.data_byte;
            known[pointer] = 1'b1;
            p = pointer;
            pointer = 16'((p & ~pmask) | ((p + 1) & pmask));
          end
        end
        OP_END: begin
          bytes_seen = 0;
        end
        OP_READ: begin
          p = pointer & cmask;
          res.read_data = mem[p];
          pointer = 16'((p + 1) & cmask);
        end
        default: begin
          mem[w.preload_address]   = w.data_byte;
          known[w.preload_address] = 1'b1;
        end
      endcase
      res.pointer_after    = pointer;
      res.address_complete = (bytes_seen >= need_bytes());
      awaited_results.push_back(res);
    endfunction

    function void check_word(out_item_t got);
      out_item_t want;
      if (awaited_results.size() == 0) begin
        $error("result word with none expected: %p", got);
        failures++;
        return;
      end
      want = awaited_results.pop_front();
      if (got.read_data !== want.read_data) begin
        $error("read_data: expected %0h, got %0h", want.read_data, got.read_data);
        failures++;
      end
      if (got.pointer_after !== want.pointer_after) begin
        $error("pointer_after: expected %0h, got %0h", want.pointer_after, got.pointer_after);
        failures++;
      end
      if (got.address_complete !== want.address_complete) begin
        $error("address_complete: expected %0b, got %0b", want.address_complete,
               got.address_complete);
        failures++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_data;
  logic       cfg_write_en = 1'b0;
  logic [1:0] cfg_index = CFG_ADDR_COUNT;
  logic [4:0] cfg_wdata = '0;

  eeprom_image sb;
  int          items_sent = 0;
  int          send_idle_pct = 15;
  int          recv_idle_pct = 65;
  int          stall_requests = 0;
  int          stalls_served = 0;
  int          stall_left = 0;
  int          cycle_count = 0;
  logic [15:0] last_addr = '0;

  int count_set [PHASES] = '{2, 1, 0, 3, 2, 1, 2, 1, 2, 3, 1};
  int chip_set  [PHASES] = '{15, 8, 16, 1, 0, 31, 4, 16, 12, 20, 2};
  int page_set  [PHASES] = '{6, 3, 8, 0, 15, 9, 2, 0, 8, 4, 1};

  i2c_eeprom_byte_engine dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_word(out_data);
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (stalls_served < stall_requests) begin
      stalls_served <= stalls_served + 1;
      stall_left    <= 300;
      out_ready     <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic in_item_t make_word(op_t op, logic [7:0] d, logic [15:0] a);
    in_item_t w;
    w.operation       = op;
    w.data_byte       = d;
    w.preload_address = a;
    return w;
  endfunction

  task automatic send_word(input in_item_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_word(w);
    items_sent++;
  endtask

  task automatic send_op(op_t op);
    send_word(make_word(op, 8'($urandom), 16'($urandom)));
  endtask

  // preload the location first if it was never written, so that no read touches unwritten memory
  task automatic read_word();
    int a;
    a = sb.read_addr();
    if (!sb.known[a]) send_word(make_word(OP_PRELOAD, 8'($urandom), 16'(a)));
    send_op(OP_READ);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic configure(logic [4:0] count, logic [4:0] chip, logic [4:0] page);
    wait_drained();
    repeat (8) @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_index    <= CFG_ADDR_COUNT;
    cfg_wdata    <= count;
    @(posedge clk);
    cfg_index <= CFG_CHIP_LOG2;
    cfg_wdata <= chip;
    @(posedge clk);
    cfg_index <= CFG_PAGE_LOG2;
    cfg_wdata <= page;
    @(posedge clk);
    cfg_index <= CFG_UNUSED;
    cfg_wdata <= 5'($urandom);
    @(posedge clk);
    cfg_write_en  <= 1'b0;
    sb.addr_count = count[1:0];
    sb.chip_log2  = chip;
    sb.page_log2  = page[3:0];
  endtask

  task automatic send_address(logic [15:0] a);
    if (sb.need_bytes() == 2) begin
      send_word(make_word(OP_WR_BYTE, a[15:8], 16'($urandom)));
      send_word(make_word(OP_WR_BYTE, a[7:0], 16'($urandom)));
    end else begin
      send_word(make_word(OP_WR_BYTE, a[7:0], 16'($urandom)));
    end
  endtask

  task automatic write_transaction();
    int n;
    logic [15:0] a;
    a = $urandom_range(1) ? 16'(last_addr + $urandom_range(3)) : 16'($urandom);
    last_addr = a;
    send_address(a);
    n = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(6);
    repeat (n) send_op(OP_WR_BYTE);
    send_op(OP_END);
  endtask

  task automatic random_read();
    int n;
    send_address(($urandom_range(9) < 7) ? last_addr : 16'($urandom));
    send_op(OP_END);
    n = $urandom_range(1, 6);
    repeat (n) read_word();
  endtask

  task automatic read_burst();
    int n;
    n = $urandom_range(1, 8);
    repeat (n) read_word();
  endtask

  task automatic preload_burst();
    int n;
    logic [15:0] a;
    n = $urandom_range(1, 4);
    for (int k = 0; k < n; k++) begin
      a = $urandom_range(1) ? 16'(sb.read_addr() + k) : 16'($urandom);
      send_word(make_word(OP_PRELOAD, 8'($urandom), a));
    end
  endtask

  task automatic noise_word();
    op_t op;
    if ($urandom_range(4) == 0) begin
      send_op(OP_WR_BYTE);
      send_op(OP_END);
    end else begin
      op = op_t'($urandom_range(3));
      if (op == OP_READ) read_word();
      else send_op(op);
    end
  endtask

  initial begin
    int target;
    int r;
    bit stall_asked;
    bit pause_done;
    sb = new();
    stall_asked = 1'b0;
    pause_done  = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    send_word(make_word(OP_PRELOAD, 8'hFF, 16'hFFFF));
    send_word(make_word(OP_PRELOAD, 8'h00, 16'h0000));
    send_word(make_word(OP_PRELOAD, 8'h5A, 16'h7FFF));
    send_word(make_word(OP_WR_BYTE, 8'hFF, 16'h0000));
    send_word(make_word(OP_WR_BYTE, 8'hFF, 16'hFFFF));
    send_word(make_word(OP_WR_BYTE, 8'h00, 16'h0000));
    send_word(make_word(OP_WR_BYTE, 8'hFF, 16'hFFFF));
    send_word(make_word(OP_END, 8'h00, 16'h0000));
    send_word(make_word(OP_WR_BYTE, 8'h12, 16'h0000));
    send_word(make_word(OP_END, 8'h34, 16'hFFFF));
    send_word(make_word(OP_WR_BYTE, 8'h7F, 16'h0000));
    read_word();
    send_word(make_word(OP_WR_BYTE, 8'hFF, 16'h0000));
    send_word(make_word(OP_END, 8'hFF, 16'h0000));
    read_word();
    read_word();
    send_word(make_word(OP_PRELOAD, 8'hC3, 16'h8000));
    read_word();
    send_word(make_word(OP_PRELOAD, 8'h3C, 16'(sb.read_addr())));
    send_word(make_word(OP_READ, 8'hFF, 16'hFFFF));

    for (int ph = 0; ph < PHASES; ph++) begin
      configure(5'(count_set[ph]), 5'(chip_set[ph]), 5'(page_set[ph]));
      send_idle_pct = (ph < 4) ? 15 : (ph < 8) ? 65 : 0;
      recv_idle_pct = (ph < 4) ? 65 : (ph < 8) ? 15 : 0;
      target = items_sent + 130;
      while (items_sent < target) begin
        if (ph == 2 && !stall_asked && items_sent >= target - 100) begin
          stall_requests <= stall_requests + 1;
          stall_asked = 1'b1;
        end
        if (ph == 6 && !pause_done && items_sent >= target - 65) begin
          wait_drained();
          pause_done = 1'b1;
        end
        r = $urandom_range(99);
        if (r < 35) write_transaction();
        else if (r < 60) random_read();
        else if (r < 75) read_burst();
        else if (r < 87) preload_burst();
        else noise_word();
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (sb.failures == 0 && sb.awaited_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/i2cee_pkg.sv
rtl/i2cee_ram.sv
rtl/i2cee_ctrl.sv
rtl/i2cee_dp.sv
rtl/i2c_eeprom_byte_engine.sv
dv/tb_i2c_eeprom_byte_engine.sv
